// File: rtl/partial_merkle_tree_builder_assert.svh
// Assertion macros shared by the partial Merkle tree builder modules.
`ifndef PARTIAL_MERKLE_TREE_BUILDER_ASSERT_SVH
`define PARTIAL_MERKLE_TREE_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define PMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pmt assertion failed");
// Check that a condition in one cycle is followed by another in the next.
`define PMT_ASSERT_NEXT(lbl, clk, rst, cause, effect) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("pmt assertion failed");
`else
`define PMT_ASSERT(lbl, clk, rst, prop)
`define PMT_ASSERT_NEXT(lbl, clk, rst, cause, effect)
`endif
`endif

// File: rtl/pmt_pkg.sv
// Shared types, constants and SHA-256 helpers of the partial Merkle tree builder.
package pmt_pkg;

   localparam int MAX_TX      = 4096;
   localparam int MAX_HEIGHT  = 12;
   localparam int STACK_DEPTH = MAX_HEIGHT + 1;
   localparam int TX_W        = 12;
   localparam int CNT_W       = 13;
   localparam int SPAN_W      = 14;
   localparam int H_W         = 4;
   localparam int SP_W        = 4;
   localparam int ID_DEPTH    = MAX_TX * 4;
   localparam int ID_AW       = 14;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_FLAG = 2'd1,
      KIND_HASH = 2'd2,
      KIND_DONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_LOAD = 2'd0,
      PH_WALK = 2'd1,
      PH_WORD = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_DECIDE,
      ST_LEAF,
      ST_CLIMB,
      ST_SHA_GO,
      ST_SHA_WAIT
   } fsm_type;

   typedef struct packed {
      logic         start;
      logic [255:0] chain;
      logic [511:0] block;
   } sha_req_type;

   typedef struct packed {
      logic         done;
      logic [255:0] digest;
   } sha_rsp_type;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // second block of a 64-byte message: marker bit and a length of 512 bits
   localparam logic [511:0] PAD_BLOCK = {32'h80000000, 448'd0, 32'h00000200};
   // tail of the single block of a 32-byte message: length of 256 bits
   localparam logic [255:0] PAD_TAIL  = {32'h80000000, 192'd0, 32'h00000100};

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

// File: rtl/pmt_sha256.sv
// SHA-256 compression unit: one round per cycle.
module pmt_sha256 import pmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  sha_req_type sha_req,
   output sha_rsp_type sha_rsp
);

   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [5:0]   round_ff, round_in;
   logic [31:0]  v_ff [8];
   logic [31:0]  v_in [8];
   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [255:0] chain_ff, chain_in;
   logic [255:0] digest_ff, digest_in;
   logic [31:0]  t1, t2, w_new;

   // one round of compression and one step of the message schedule
   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      round_in  = round_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      chain_in  = chain_ff;
      digest_in = digest_ff;
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + SHA_K[round_ff] + w_ff[0];
      t2 = big_sigma0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
           ^ (v_ff[1] & v_ff[2]));
      w_new = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);
      if (sha_req.start) begin
         run_in   = 1'b1;
         round_in = '0;
         chain_in = sha_req.chain;
         for (int k = 0; k < 8; k++) begin
            v_in[k] = sha_req.chain[255 - 32 * k -: 32];
         end
         for (int j = 0; j < 16; j++) begin
            w_in[j] = sha_req.block[511 - 32 * j -: 32];
         end
      end else if (run_ff) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int j = 0; j < 15; j++) begin
            w_in[j] = w_ff[j + 1];
         end
         w_in[15] = w_new;
         round_in = round_ff + 6'd1;
         // fold the working variables into the chain value after the last round
         if (round_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            for (int k = 0; k < 8; k++) begin
               digest_in[255 - 32 * k -: 32] = chain_ff[255 - 32 * k -: 32] + v_in[k];
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      w_ff      <= w_in;
      chain_ff  <= chain_in;
      digest_ff <= digest_in;
   end

   assign sha_rsp.done   = done_ff;
   assign sha_rsp.digest = digest_ff;

endmodule

// File: rtl/partial_merkle_tree_builder.sv
// Partial Merkle tree builder: a load beat, one hash word or a finished answer is
// answered straight from idle. A fetch that visits a node scans the match flags
// under it until the first match or the end of its span, and a node that is
// hashed reads the id words of its leaves and runs three SHA-256 compressions
// per inner node, all through the one compression unit. The block accepts no
// beat while a fetch is at work or a result waits to be taken. Memories need
// no clearing pass after reset.
`include "partial_merkle_tree_builder_assert.svh"
module partial_merkle_tree_builder import pmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tx_index[11:0], word_sel[13:12], id_word[77:14], tx_matches[78], zero[79]
   input  logic [79:0] req_tdata,
   // req_type[0]
   input  logic        req_tuser,
   // last_tx
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // node_flag[0], hash_word[64:1], hash_word_sel[66:65], tx_total_out[79:67]
   output logic [79:0] rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]  rsp_tuser
);

   fsm_type            state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         word_ff, word_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [SP_W-1:0]    vcount_ff, vcount_in;
   logic [H_W-1:0]     vst_h_ff [STACK_DEPTH];
   logic [H_W-1:0]     vst_h_in [STACK_DEPTH];
   logic [TX_W-1:0]    vst_p_ff [STACK_DEPTH];
   logic [TX_W-1:0]    vst_p_in [STACK_DEPTH];
   logic [H_W-1:0]     node_h_ff, node_h_in;
   logic [TX_W-1:0]    node_p_ff, node_p_in;
   logic               flag_ff, flag_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic [SPAN_W-1:0]  end_ff, end_in;
   logic [H_W-1:0]     cur_l_ff, cur_l_in;
   logic [CNT_W-1:0]   cur_p_ff, cur_p_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [1:0]         step_ff, step_in;
   logic [255:0]       x_ff, x_in;
   logic [255:0]       slot_ff [STACK_DEPTH];
   logic [255:0]       slot_in [STACK_DEPTH];
   logic [511:0]       blk_ff, blk_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic               rsp_flag_ff, rsp_flag_in;
   logic [63:0]        rsp_word_ff, rsp_word_in;
   logic [1:0]         rsp_wsel_ff, rsp_wsel_in;
   logic [CNT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic [63:0]        id_mem [ID_DEPTH];
   logic               match_mem [MAX_TX];
   logic               id_we, match_we;
   logic [ID_AW-1:0]   id_waddr, id_raddr;
   logic [TX_W-1:0]    match_raddr;
   logic [63:0]        id_rd_ff;
   logic               match_rd_ff;

   sha_req_type        sha_req;
   sha_rsp_type        sha_rsp;

   logic               accept;
   logic [TX_W-1:0]    in_idx;
   logic [1:0]         in_wsel;
   logic [63:0]        in_word;
   logic               in_match;
   logic [H_W-1:0]     in_height;
   logic [SP_W-1:0]    top_idx;
   logic [H_W-1:0]     pop_h;
   logic [TX_W-1:0]    pop_p;
   logic [SPAN_W-1:0]  pop_start, pop_end;
   logic [SPAN_W-1:0]  right_start, next_start;
   logic [SP_W-1:0]    push_idx;

   assign in_idx   = req_tdata[11:0];
   assign in_wsel  = req_tdata[13:12];
   assign in_word  = req_tdata[77:14];
   assign in_match = req_tdata[78];

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // tree height: bit length of the last index
   always_comb begin
      in_height = '0;
      for (int i = 0; i < TX_W; i++) begin
         if (in_idx[i]) begin
            in_height = H_W'(i + 1);
         end
      end
   end

   // span of leaves under the node on top of the visit stack
   assign top_idx   = vcount_ff - SP_W'(1);
   assign pop_h     = vst_h_ff[top_idx];
   assign pop_p     = vst_p_ff[top_idx];
   assign pop_start = SPAN_W'(pop_p) << pop_h;
   assign pop_end   = (SPAN_W'(pop_p) + SPAN_W'(1)) << pop_h;

   assign right_start = SPAN_W'({node_p_ff, 1'b1}) << (node_h_ff - H_W'(1));
   assign next_start  = (SPAN_W'(cur_p_ff) + SPAN_W'(1)) << cur_l_ff;

   // sequencer: load and answer beats, subtree scan, hash walk
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      word_in      = word_ff;
      total_in     = total_ff;
      vcount_in    = vcount_ff;
      vst_h_in     = vst_h_ff;
      vst_p_in     = vst_p_ff;
      node_h_in    = node_h_ff;
      node_p_in    = node_p_ff;
      flag_in      = flag_ff;
      scan_in      = scan_ff;
      end_in       = end_ff;
      cur_l_in     = cur_l_ff;
      cur_p_in     = cur_p_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      slot_in      = slot_ff;
      blk_in       = blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_wsel_in  = rsp_wsel_ff;
      rsp_total_in = rsp_total_ff;
      id_we        = 1'b0;
      match_we     = 1'b0;
      id_waddr     = {in_idx, in_wsel};
      id_raddr     = {cur_p_ff[TX_W-1:0], cnt_ff[1:0]};
      match_raddr  = scan_ff[TX_W-1:0];
      push_idx     = vcount_ff + SP_W'(1);
      sha_req.start = 1'b0;
      sha_req.chain = (step_ff == 2'd1) ? sha_rsp.digest : SHA_IV;
      case (step_ff)
         2'd0:    sha_req.block = blk_ff;
         2'd1:    sha_req.block = PAD_BLOCK;
         default: sha_req.block = {sha_rsp.digest, PAD_TAIL};
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = 1'b0;
               rsp_word_in  = '0;
               rsp_wsel_in  = '0;
               rsp_total_in = '0;
               if (req_tuser == REQ_LOAD) begin
                  // store the word and restart from loading
                  id_we       = 1'b1;
                  match_we    = 1'b1;
                  rsp_kind_in = KIND_ACK;
                  phase_in    = PH_LOAD;
                  vcount_in   = '0;
                  if (req_tlast) begin
                     total_in    = CNT_W'(in_idx) + CNT_W'(1);
                     vst_h_in[0] = in_height;
                     vst_p_in[0] = '0;
                     vcount_in   = SP_W'(1);
                     phase_in    = PH_WALK;
                  end
               end else if (phase_ff == PH_WORD) begin
                  // hand out the next word of the pending hash
                  rsp_kind_in = KIND_HASH;
                  rsp_wsel_in = word_ff;
                  case (word_ff)
                     2'd0:    rsp_word_in = x_ff[255:192];
                     2'd1:    rsp_word_in = x_ff[191:128];
                     2'd2:    rsp_word_in = x_ff[127:64];
                     default: rsp_word_in = x_ff[63:0];
                  endcase
                  word_in = word_ff + 2'd1;
                  if (word_ff == 2'd3) begin
                     phase_in = PH_WALK;
                  end
               end else if (phase_ff == PH_WALK && vcount_ff != '0) begin
                  // pop a node and scan its leaves; the answer comes later
                  rsp_valid_in = 1'b0;
                  vcount_in    = top_idx;
                  node_h_in    = pop_h;
                  node_p_in    = pop_p;
                  flag_in      = 1'b0;
                  scan_in      = CNT_W'(pop_start);
                  end_in       = (pop_end < SPAN_W'(total_ff)) ? pop_end : SPAN_W'(total_ff);
                  state_in     = ST_SCAN_RD;
               end else begin
                  rsp_kind_in  = KIND_DONE;
                  rsp_total_in = total_ff;
                  if (phase_ff != PH_LOAD) begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CK;
         end
         ST_SCAN_CK: begin
            // stop at the first match or at the end of the span
            if (match_rd_ff) begin
               flag_in  = 1'b1;
               state_in = ST_DECIDE;
            end else if (SPAN_W'(scan_ff) + SPAN_W'(1) >= end_ff) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_DECIDE: begin
            if (node_h_ff == '0 || !flag_ff) begin
               // hash the subtree, starting at its first leaf
               cur_l_in = '0;
               cur_p_in = CNT_W'(SPAN_W'(node_p_ff) << node_h_ff);
               cnt_in   = '0;
               state_in = ST_LEAF;
            end else begin
               // descend: right child below left child on the stack
               if (right_start < SPAN_W'(total_ff)) begin
                  if (vcount_ff < SP_W'(STACK_DEPTH)) begin
                     vst_h_in[vcount_ff] = node_h_ff - H_W'(1);
                     vst_p_in[vcount_ff] = {node_p_ff[TX_W-2:0], 1'b1};
                  end
                  if (push_idx < SP_W'(STACK_DEPTH)) begin
                     vst_h_in[push_idx] = node_h_ff - H_W'(1);
                     vst_p_in[push_idx] = {node_p_ff[TX_W-2:0], 1'b0};
                  end
                  vcount_in = vcount_ff + SP_W'(2);
               end else begin
                  if (vcount_ff < SP_W'(STACK_DEPTH)) begin
                     vst_h_in[vcount_ff] = node_h_ff - H_W'(1);
                     vst_p_in[vcount_ff] = {node_p_ff[TX_W-2:0], 1'b0};
                  end
                  vcount_in = vcount_ff + SP_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FLAG;
               rsp_flag_in  = 1'b1;
               rsp_word_in  = '0;
               rsp_wsel_in  = '0;
               rsp_total_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_LEAF: begin
            // read the four id words, one read in flight
            case (cnt_ff)
               3'd1:    x_in[255:192] = id_rd_ff;
               3'd2:    x_in[191:128] = id_rd_ff;
               3'd3:    x_in[127:64]  = id_rd_ff;
               3'd4:    x_in[63:0]    = id_rd_ff;
               default: x_in = x_ff;
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = ST_CLIMB;
            end
         end
         ST_CLIMB: begin
            if (cur_l_ff == node_h_ff) begin
               // subtree hash ready: answer the node flag
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FLAG;
               rsp_flag_in  = flag_ff;
               rsp_word_in  = '0;
               rsp_wsel_in  = '0;
               rsp_total_in = '0;
               phase_in     = PH_WORD;
               word_in      = '0;
               state_in     = ST_IDLE;
            end else if (!cur_p_ff[0] && next_start < SPAN_W'(total_ff)) begin
               // hold the left hash and go hash the right sibling
               slot_in[cur_l_ff] = x_ff;
               cur_p_in = CNT_W'(next_start);
               cur_l_in = '0;
               cnt_in   = '0;
               state_in = ST_LEAF;
            end else begin
               blk_in   = cur_p_ff[0] ? {slot_ff[cur_l_ff], x_ff} : {x_ff, x_ff};
               step_in  = '0;
               state_in = ST_SHA_GO;
            end
         end
         ST_SHA_GO: begin
            sha_req.start = 1'b1;
            state_in      = ST_SHA_WAIT;
         end
         ST_SHA_WAIT: begin
            // two blocks of the first pass, then the second pass
            if (sha_rsp.done) begin
               if (step_ff == 2'd2) begin
                  x_in     = sha_rsp.digest;
                  cur_l_in = cur_l_ff + H_W'(1);
                  cur_p_in = cur_p_ff >> 1;
                  state_in = ST_CLIMB;
               end else begin
                  step_in  = step_ff + 2'd1;
                  state_in = ST_SHA_GO;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   pmt_sha256 u_sha (
      .clock   (clock),
      .reset   (reset),
      .sha_req (sha_req),
      .sha_rsp (sha_rsp)
   );

   // id words and match flags
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= in_word;
      end
      id_rd_ff <= id_mem[id_raddr];
   end

   always_ff @(posedge clock) begin
      if (match_we) begin
         match_mem[in_idx] <= in_match;
      end
      match_rd_ff <= match_mem[match_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LOAD;
         word_ff      <= '0;
         total_ff     <= '0;
         vcount_ff    <= '0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         scan_ff      <= '0;
         end_ff       <= '0;
         cur_l_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         word_ff      <= word_in;
         total_ff     <= total_in;
         vcount_ff    <= vcount_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         scan_ff      <= scan_in;
         end_ff       <= end_in;
         cur_l_ff     <= cur_l_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      vst_h_ff     <= vst_h_in;
      vst_p_ff     <= vst_p_in;
      node_h_ff    <= node_h_in;
      node_p_ff    <= node_p_in;
      flag_ff      <= flag_in;
      cur_p_ff     <= cur_p_in;
      x_ff         <= x_in;
      slot_ff      <= slot_in;
      blk_ff       <= blk_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_wsel_ff  <= rsp_wsel_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_wsel_ff, rsp_word_ff, rsp_flag_ff};
   assign rsp_tuser  = rsp_kind_ff;

   `PMT_ASSERT_NEXT(a_accept_blocks, clock, reset, req_tvalid && req_tready, !req_tready)
   `PMT_ASSERT(a_busy_no_rsp, clock, reset, (state_ff != ST_IDLE) |-> !rsp_valid_ff)
   `PMT_ASSERT(a_sha_done_wait, clock, reset, sha_rsp.done |-> (state_ff == ST_SHA_WAIT))
   `PMT_ASSERT(a_stack_bound, clock, reset, vcount_ff <= SP_W'(STACK_DEPTH))

endmodule

// File: tb/partial_merkle_tree_builder_tb.sv
// Self-checking testbench of the partial Merkle tree builder with a tree predictor.
`timescale 1ns / 100ps
module partial_merkle_tree_builder_tb;
   import pmt_pkg::*;

   localparam int TREE_SLOTS = MAX_TX;
   localparam int HEIGHT_CAP = MAX_HEIGHT;
   localparam int DEPTH_CAP  = HEIGHT_CAP + 1;
   localparam int CYCLE_CAP  = 50000000;
   localparam int ITEM_GOAL  = 1350;

   typedef struct {
      logic        kind;
      logic [11:0] idx;
      logic [1:0]  wsel;
      logic [63:0] word;
      logic        hit;
      logic        last;
   } beat_type;

   typedef struct {
      kind_type    kind;
      logic        flag;
      logic [63:0] word;
      logic [1:0]  sel;
      logic [12:0] total;
   } answer_type;

   typedef enum logic [1:0] {W_LOAD, W_WALK, W_WORD, W_DONE} walk_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   beat_type   pending_beats[$];
   answer_type expected_answers[$];
   beat_type   cur_beat;
   int         accepted_beats;
   int         cycle_count;
   bit         failed;

   // predictor state
   logic [63:0] id_mem [0:TREE_SLOTS*4-1];
   logic        hit_mem [0:TREE_SLOTS-1];
   int          leaf_total;
   int          stack_h [0:DEPTH_CAP-1];
   int          stack_p [0:DEPTH_CAP-1];
   int          stack_n;
   logic [255:0] out_hash;
   int          out_sel;
   walk_type    walk;

   logic [31:0] round_k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [255:0] INIT_STATE = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   partial_merkle_tree_builder i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one SHA-256 compression of a 512-bit block
   function automatic logic [255:0] compress(input logic [255:0] st, input logic [511:0] blk);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      {a, b, c, d, e, f, g, h} = st;
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + round_k[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      return {st[255:224] + a, st[223:192] + b, st[191:160] + c, st[159:128] + d,
              st[127:96] + e, st[95:64] + f, st[63:32] + g, st[31:0] + h};
   endfunction

   function automatic int width_at(input int h);
      return (leaf_total + (1 << h) - 1) >> h;
   endfunction

   // hash of the node at height h and position p, word 0 in the top bits
   function automatic logic [255:0] tree_hash(input int h, input int p);
      logic [255:0] lft, rgt, d1;
      if (h == 0)
         return {id_mem[p*4], id_mem[p*4+1], id_mem[p*4+2], id_mem[p*4+3]};
      lft = tree_hash(h - 1, 2*p);
      rgt = (2*p + 1 < width_at(h - 1)) ? tree_hash(h - 1, 2*p + 1) : lft;
      d1 = compress(compress(INIT_STATE, {lft, rgt}), {32'h80000000, 448'd0, 32'd512});
      return compress(INIT_STATE, {d1, 32'h80000000, 192'd0, 32'd256});
   endfunction

   function automatic bit any_hit(input int h, input int p);
      int stop;
      stop = (p + 1) << h;
      if (stop > leaf_total) stop = leaf_total;
      for (int i = p << h; i < stop; i++) if (hit_mem[i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void push_node(input int h, input int p);
      if (stack_n < DEPTH_CAP) begin
         stack_h[stack_n] = h;
         stack_p[stack_n] = p;
         stack_n++;
      end
   endfunction

   // advance the predicted tree walk by one accepted beat
   function automatic void predict_beat(input beat_type bt);
      answer_type ans;
      int h, p, top;
      bit hit;
      ans = '{KIND_ACK, 1'b0, 64'd0, 2'd0, 13'd0};
      if (bt.kind == REQ_LOAD) begin
         walk = W_LOAD;
         stack_n = 0;
         id_mem[bt.idx*4 + bt.wsel] = bt.word;
         hit_mem[bt.idx] = bt.hit;
         if (bt.last) begin
            leaf_total = bt.idx + 1;
            top = 0;
            while (top < HEIGHT_CAP && width_at(top) > 1) top++;
            push_node(top, 0);
            walk = W_WALK;
         end
      end else if (walk == W_WORD) begin
         ans.kind = KIND_HASH;
         ans.word = out_hash[255 - 64*out_sel -: 64];
         ans.sel = out_sel[1:0];
         out_sel++;
         if (out_sel == 4) walk = W_WALK;
      end else if (walk == W_WALK && stack_n > 0) begin
         stack_n--;
         h = stack_h[stack_n];
         p = stack_p[stack_n];
         hit = any_hit(h, p);
         ans.kind = KIND_FLAG;
         ans.flag = hit;
         if (h == 0 || !hit) begin
            out_hash = tree_hash(h, p);
            out_sel = 0;
            walk = W_WORD;
         end else begin
            if (2*p + 1 < width_at(h - 1)) push_node(h - 1, 2*p + 1);
            push_node(h - 1, 2*p);
         end
      end else begin
         if (walk != W_LOAD) walk = W_DONE;
         ans.kind = KIND_DONE;
         ans.total = leaf_total[12:0];
      end
      expected_answers = {expected_answers, ans};
   endfunction

   function automatic int idle_pct(input bit rx_side);
      if (accepted_beats < ITEM_GOAL / 3) return rx_side ? 55 : 23;
      if (accepted_beats < 2 * ITEM_GOAL / 3) return rx_side ? 23 : 55;
      return 0;
   endfunction

   // drive request beats, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         req_tlast <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_beat(cur_beat);
            accepted_beats++;
         end
         if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
            cur_beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= cur_beat.kind;
            req_tlast <= cur_beat.last;
            req_tdata <= {1'b0, cur_beat.hit, cur_beat.word, cur_beat.wsel, cur_beat.idx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // randomize result backpressure and check each result beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct(1'b1));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected result kind=%0d data=%h", $realtime, rsp_tuser, rsp_tdata);
               failed = 1'b1;
            end else begin
               answer_type ex;
               ex = expected_answers.pop_front();
               if (rsp_tuser != ex.kind || rsp_tdata[0] != ex.flag ||
                   rsp_tdata[64:1] != ex.word || rsp_tdata[66:65] != ex.sel ||
                   rsp_tdata[79:67] != ex.total) begin
                  $display("%0t: mismatch expected kind=%0d flag=%0d word=%h sel=%0d total=%0d",
                           $realtime, ex.kind, ex.flag, ex.word, ex.sel, ex.total);
                  $display("%0t:          actual kind=%0d flag=%0d word=%h sel=%0d total=%0d",
                           $realtime, rsp_tuser, rsp_tdata[0], rsp_tdata[64:1],
                           rsp_tdata[66:65], rsp_tdata[79:67]);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // end the run on a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   int queued;

   task automatic add_load(input int idx, input int wsel, input logic [63:0] word,
                           input bit hit, input bit last);
      beat_type bt;
      bt = '{REQ_LOAD, idx[11:0], wsel[1:0], word, hit, last};
      pending_beats = {pending_beats, bt};
      queued++;
   endtask

   task automatic add_fetch();
      beat_type bt;
      bt = '{REQ_FETCH, 12'($urandom), 2'($urandom), {$urandom, $urandom},
             1'($urandom), 1'($urandom)};
      pending_beats = {pending_beats, bt};
      queued++;
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_tvalid) @(negedge clock);
   endtask

   function automatic logic [63:0] rand_word(input int style);
      case (style)
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // load a whole block of n transactions, then walk it (all of it if walk_all); mode picks the match pattern
   task automatic run_frame(input int n, input int mode, input int style, input bit walk_all);
      bit hit;
      for (int t = 0; t < n; t++) begin
         case (mode)
            0: hit = 1'b0;
            1: hit = 1'b1;
            2: hit = (t == n - 1);
            default: hit = ($urandom_range(99) < 20);
         endcase
         for (int w = 0; w < 4; w++) begin
            // overwrite a word now and then; the later flag and word win
            if ($urandom_range(99) < 8) add_load(t, w, rand_word(2), !hit, 1'b0);
            add_load(t, w, rand_word(style), hit, (t == n - 1) && (w == 3));
         end
      end
      drain();
      while (walk != W_DONE) begin
         if (!walk_all && $urandom_range(99) < 4) return;
         repeat ($urandom_range(1, 6)) add_fetch();
         drain();
      end
      repeat ($urandom_range(0, 2)) add_fetch();
   endtask

   initial begin
      int n;
      failed = 1'b0;
      accepted_beats = 0;
      cycle_count = 0;
      queued = 0;
      leaf_total = 0;
      stack_n = 0;
      walk = W_LOAD;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fetch while still loading
      add_fetch();
      // single leaf, then trees of two and three leaves; three leaves give an odd width so the left child is reused
      run_frame(1, 1, 1, 1'b1);
      run_frame(1, 0, 0, 1'b1);
      run_frame(2, 2, 0, 1'b1);
      run_frame(3, 2, 2, 1'b1);
      // saturated count: last at the top index, then drop the walk before any read
      add_load(4095, 3, '1, 1'b1, 1'b1);
      add_load(0, 0, '0, 1'b0, 1'b0);
      add_fetch();
      drain();

      // random blocks with noise and aborted walks between them
      while (queued < ITEM_GOAL) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, 12);
            7, 8: n = $urandom_range(13, 24);
            default: n = $urandom_range(25, 40);
         endcase
         run_frame(n, $urandom_range(3), ($urandom_range(9) == 0) ? $urandom_range(1) : 2,
                   $urandom_range(99) >= 15);
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(1)) add_fetch();
            else add_load($urandom_range(0, 4095), $urandom_range(0, 3), rand_word(2),
                          1'($urandom), 1'b0);
         end
      end

      drain();
      while (expected_answers.size() > 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (!failed && expected_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
